// ===== rtl/core/mcpd_pkg.sv =====
// shared types and constants for the masked cmyk page difference block
// no dependencies; used by the interfaces, the pixel evaluator and the top level

package mcpd_pkg;

	localparam int MAX_RECTS_DEF  = 4;
	localparam int COORD_BITS_DEF = 16;

	localparam int CHAN_W     = 8;
	localparam int THRESH_W   = 8;
	localparam int WIDTH_W    = 16;
	localparam int RCOUNT_W   = 3;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int PACK_W     = 16;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD  = 3'd0,
		REG_PAGE_WIDTH = 3'd1,
		REG_RECT_COUNT = 3'd2,
		REG_RECT0      = 3'd3,
		REG_RECT1      = 3'd4,
		REG_RECT2      = 3'd5,
		REG_RECT3      = 3'd6
	} cfg_reg_t;

	// rectangle coordinate slots inside one packed register
	typedef enum logic [1:0] {
		CRD_LEFT   = 2'd0,
		CRD_TOP    = 2'd1,
		CRD_RIGHT  = 2'd2,
		CRD_BOTTOM = 2'd3
	} coord_sel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] tgt_cyan;
		logic [CHAN_W-1:0] tgt_magenta;
		logic [CHAN_W-1:0] tgt_yellow;
		logic [CHAN_W-1:0] tgt_black;
		logic [CHAN_W-1:0] src_cyan;
		logic [CHAN_W-1:0] src_magenta;
		logic [CHAN_W-1:0] src_yellow;
		logic [CHAN_W-1:0] src_black;
	} pixel_pair_t;

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// ===== rtl/core/mcpd_if.sv =====
// stream interfaces for the pixel pair input and the page result output
// depends on mcpd_pkg for the channel width

interface mcpd_pix_if;
	logic                        valid;
	logic                        ready;
	logic [mcpd_pkg::CHAN_W-1:0] tgt_cyan;
	logic [mcpd_pkg::CHAN_W-1:0] tgt_magenta;
	logic [mcpd_pkg::CHAN_W-1:0] tgt_yellow;
	logic [mcpd_pkg::CHAN_W-1:0] tgt_black;
	logic [mcpd_pkg::CHAN_W-1:0] src_cyan;
	logic [mcpd_pkg::CHAN_W-1:0] src_magenta;
	logic [mcpd_pkg::CHAN_W-1:0] src_yellow;
	logic [mcpd_pkg::CHAN_W-1:0] src_black;
	logic                        last_pixel;

	modport source (output valid, tgt_cyan, tgt_magenta, tgt_yellow, tgt_black,
		src_cyan, src_magenta, src_yellow, src_black, last_pixel, input ready);
	modport sink (input valid, tgt_cyan, tgt_magenta, tgt_yellow, tgt_black,
		src_cyan, src_magenta, src_yellow, src_black, last_pixel, output ready);
endinterface

interface mcpd_res_if;
	logic valid;
	logic ready;
	logic page_differs;

	modport source (output valid, page_differs, input ready);
	modport sink (input valid, page_differs, output ready);
endinterface

// ===== rtl/core/mcpd_eval.sv =====
// per-pixel evaluation: exclusion rectangle test and thresholded channel difference
// depends on mcpd_pkg

module mcpd_eval #(
	parameter int MAX_RECTS  = mcpd_pkg::MAX_RECTS_DEF,
	parameter int COORD_BITS = mcpd_pkg::COORD_BITS_DEF
) (
	input  mcpd_pkg::pixel_pair_t                     pixel,
	input  logic [COORD_BITS-1:0]                     col,
	input  logic [COORD_BITS-1:0]                     row,
	input  logic [mcpd_pkg::THRESH_W-1:0]             threshold,
	input  logic [mcpd_pkg::RCOUNT_W-1:0]             rect_count,
	input  logic [MAX_RECTS-1:0][3:0][COORD_BITS-1:0] rects,
	output logic                                      hit
);

	localparam logic [mcpd_pkg::RCOUNT_W-1:0] RMAX = mcpd_pkg::RCOUNT_W'(MAX_RECTS);

	logic [mcpd_pkg::RCOUNT_W-1:0] active;
	logic [MAX_RECTS-1:0]          in_rect;
	logic                          excluded;
	logic [3:0]                    over;

	assign active = (rect_count > RMAX) ? RMAX : rect_count;

	for (genvar i = 0; i < MAX_RECTS; i++) begin : g_rect
		assign in_rect[i] = (mcpd_pkg::RCOUNT_W'(i) < active)
			&& (col >= rects[i][mcpd_pkg::CRD_LEFT])
			&& (col <  rects[i][mcpd_pkg::CRD_RIGHT])
			&& (row >= rects[i][mcpd_pkg::CRD_TOP])
			&& (row <  rects[i][mcpd_pkg::CRD_BOTTOM]);
	end

	assign excluded = |in_rect;

	// any channel over threshold is the same as the largest one over it
	assign over[0] = mcpd_pkg::abs_diff(pixel.tgt_cyan, pixel.src_cyan) > threshold;
	assign over[1] = mcpd_pkg::abs_diff(pixel.tgt_magenta, pixel.src_magenta) > threshold;
	assign over[2] = mcpd_pkg::abs_diff(pixel.tgt_yellow, pixel.src_yellow) > threshold;
	assign over[3] = mcpd_pkg::abs_diff(pixel.tgt_black, pixel.src_black) > threshold;

	assign hit = !excluded && (|over);

endmodule

// ===== rtl/core/masked_cmyk_page_diff.sv =====
// top level of the masked cmyk page difference block
// depends on mcpd_pkg, mcpd_if and mcpd_eval
//
// usage:
//   pix carries one target/source pixel pair per transfer in raster order,
//   last_pixel high on the page's final pixel. res carries one page_differs
//   bit per page, set when any pixel outside the active exclusion
//   rectangles differs by more than the threshold in some channel.
//   configuration is a plain write port (cfg_write, cfg_index, cfg_data), to be written
//   only while the block is idle, a user rule it does not enforce; unknown indexes are dropped.
// timing:
//   one pixel pair per cycle sustained while no stall holds pix.ready low.
//   a page's last pixel passes through one input register stage feeding the
//   evaluation logic, then sets the result register that drives res.valid.
// reset:
//   arst_n clears the pipeline, counters and flag; threshold 0, page width 1,
//   no rectangles.
// stall:
//   a result waits in the output register; pixels keep flowing until a
//   further last pixel reaches the input stage while that result is still
//   unread, which holds pix.ready low until res transfers.

module masked_cmyk_page_diff #(
	parameter int MAX_RECTS  = mcpd_pkg::MAX_RECTS_DEF,
	parameter int COORD_BITS = mcpd_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	mcpd_pix_if.sink                          pix,
	mcpd_res_if.source                        res,
	input  logic                              cfg_write,
	input  logic [mcpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mcpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [mcpd_pkg::THRESH_W-1:0]             threshold_q;
	logic [mcpd_pkg::WIDTH_W-1:0]              page_width_q;
	logic [mcpd_pkg::RCOUNT_W-1:0]             rect_count_q;
	logic [MAX_RECTS-1:0][3:0][COORD_BITS-1:0] rect_q;

	logic [COORD_BITS-1:0] col_q, row_q, col_next;
	logic                  differs_q;

	logic                  valid_s1, last_s1;
	mcpd_pkg::pixel_pair_t pixel_s1;
	logic [COORD_BITS-1:0] col_s1, row_s1;

	logic out_valid_q, out_differs_q;
	logic pix_fire, adv_s1, hit, seen;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= '0;
			page_width_q <= mcpd_pkg::WIDTH_W'(1);
			rect_count_q <= '0;
			rect_q       <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				mcpd_pkg::REG_THRESHOLD:  threshold_q  <= cfg_data[mcpd_pkg::THRESH_W-1:0];
				mcpd_pkg::REG_PAGE_WIDTH: page_width_q <= cfg_data[mcpd_pkg::WIDTH_W-1:0];
				mcpd_pkg::REG_RECT_COUNT: rect_count_q <= cfg_data[mcpd_pkg::RCOUNT_W-1:0];
				default: begin
					for (int i = 0; i < MAX_RECTS; i++) begin
						if (cfg_index == mcpd_pkg::REG_RECT0 + mcpd_pkg::CFG_IDX_W'(i)) begin
							for (int k = 0; k < 4; k++) begin
								rect_q[i][k] <= cfg_data[k*mcpd_pkg::PACK_W +: COORD_BITS];
							end
						end
					end
				end
			endcase
		end
	end

	// input stage moves on unless it holds a last pixel and the result is still unread
	assign adv_s1    = valid_s1 && !(last_s1 && out_valid_q && !res.ready);
	assign pix.ready = !valid_s1 || adv_s1;
	assign pix_fire  = pix.valid && pix.ready;

	assign col_next = col_q + COORD_BITS'(1);

	// position counters, advanced per input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_fire) begin
			if (pix.last_pixel) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_next == '0
					|| mcpd_pkg::WIDTH_W'(col_next) >= page_width_q) begin
				col_q <= '0;
				row_q <= row_q + COORD_BITS'(1);
			end else begin
				col_q <= col_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			pixel_s1 <= '{tgt_cyan: pix.tgt_cyan, tgt_magenta: pix.tgt_magenta,
				tgt_yellow: pix.tgt_yellow, tgt_black: pix.tgt_black,
				src_cyan: pix.src_cyan, src_magenta: pix.src_magenta,
				src_yellow: pix.src_yellow, src_black: pix.src_black};
			last_s1  <= pix.last_pixel;
			col_s1   <= col_q;
			row_s1   <= row_q;
		end
	end

	mcpd_eval #(
		.MAX_RECTS  (MAX_RECTS),
		.COORD_BITS (COORD_BITS)
	) u_eval (
		.pixel      (pixel_s1),
		.col        (col_s1),
		.row        (row_s1),
		.threshold  (threshold_q),
		.rect_count (rect_count_q),
		.rects      (rect_q),
		.hit        (hit)
	);

	assign seen = differs_q || hit;

	// sticky flag and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			differs_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				differs_q <= last_s1 ? 1'b0 : seen;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_differs_q <= seen;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.page_differs = out_differs_q;

endmodule

// ===== rtl/core/mcpd_checker.sv =====
// port-level checks for masked_cmyk_page_diff, attached by bind
// depends on the top level's port names only

module mcpd_checker (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	input logic pix_ready,
	input logic pix_last,
	input logic res_valid,
	input logic res_ready,
	input logic res_page_differs
);

	// a stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_page_differs))
		else $error("result changed while stalled");

	// with no result waiting the input side never stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("input stalled with empty result register");

	// a fresh result follows a last pixel transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pix_valid && pix_ready && pix_last, 2))
		else $error("result without a last pixel");

	// a non-last pixel transfer never produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && !pix_last && !res_valid |=> ##1 !$rose(res_valid))
		else $error("result after a pixel that was not last");

endmodule

bind masked_cmyk_page_diff mcpd_checker u_mcpd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.pix_valid        (pix.valid),
	.pix_ready        (pix.ready),
	.pix_last         (pix.last_pixel),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_page_differs (res.page_differs)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for masked_cmyk_page_diff: directed pages, then random pages
// under many register settings, each page flag checked against a typed value or an in-bench predictor
// depends on mcpd_pkg, mcpd_if and the rtl of the block

module testbench;
	import mcpd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7; // index outside the register map
	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 5000;
	localparam int PAGE_TAIL    = 4;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_PIXELS = 104;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		pixel_pair_t pair;
		logic        last;
	} pixel_item_t;

	typedef enum bit {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		pixel_item_t           item;
		bit                    typed;
		bit                    typed_val;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mcpd_pix_if pix_ch();
	mcpd_res_if res_ch();

	masked_cmyk_page_diff u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_ch),
		.res       (res_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of the registers and page state
	logic [THRESH_W-1:0]       thr_q;
	logic [WIDTH_W-1:0]        width_q;
	logic [RCOUNT_W-1:0]       rcount_q;
	logic [CFG_DATA_W-1:0]     rect_q [MAX_RECTS_DEF];
	logic [COORD_BITS_DEF-1:0] col_q;
	logic [COORD_BITS_DEF-1:0] row_q;
	bit                        differs_q;

	bit       differs_due[$];
	dir_row_t dir_rows[$];
	int       mismatches = 0;
	int       quiet_cycles = 0;
	bit       gaps_on = 1;
	bit       hold_req = 0;

	function automatic logic [CFG_DATA_W-1:0] rect_pack(input logic [15:0] l, t, r, b);
		return {b, r, t, l};
	endfunction

	function automatic bit pixel_masked(input logic [15:0] x, input logic [15:0] y);
		int active;
		logic [PACK_W-1:0] l, t, r, b;
		active = (rcount_q > MAX_RECTS_DEF) ? MAX_RECTS_DEF : int'(rcount_q);
		for (int i = 0; i < active; i++) begin
			l = rect_q[i][PACK_W*CRD_LEFT +: PACK_W];
			t = rect_q[i][PACK_W*CRD_TOP +: PACK_W];
			r = rect_q[i][PACK_W*CRD_RIGHT +: PACK_W];
			b = rect_q[i][PACK_W*CRD_BOTTOM +: PACK_W];
			if (x >= l && x < r && y >= t && y < b)
				return 1;
		end
		return 0;
	endfunction

	// advances the page state by one pixel; done marks a page end with its flag
	function automatic void page_diff_step(input pixel_item_t it, output bit done,
			output bit differs);
		logic [CHAN_W-1:0] tch [4];
		logic [CHAN_W-1:0] sch [4];
		logic [CHAN_W-1:0] gap;
		logic [CHAN_W-1:0] widest;
		logic [15:0]       nxt;
		tch = '{it.pair.tgt_cyan, it.pair.tgt_magenta, it.pair.tgt_yellow, it.pair.tgt_black};
		sch = '{it.pair.src_cyan, it.pair.src_magenta, it.pair.src_yellow, it.pair.src_black};
		if (!pixel_masked(col_q, row_q)) begin
			widest = 0;
			for (int c = 0; c < 4; c++) begin
				gap = (tch[c] > sch[c]) ? tch[c] - sch[c] : sch[c] - tch[c];
				if (gap > widest)
					widest = gap;
			end
			if (widest > thr_q)
				differs_q = 1;
		end
		done = it.last;
		differs = differs_q;
		if (it.last) begin
			differs_q = 0;
			col_q = 0;
			row_q = 0;
		end else begin
			nxt = col_q + 16'd1;
			// zero width wraps on every pixel
			if (nxt >= width_q || nxt == 16'd0) begin
				col_q = 0;
				row_q = row_q + 16'd1;
			end else begin
				col_q = nxt;
			end
		end
	endfunction

	function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_THRESHOLD:  thr_q = data[THRESH_W-1:0];
			REG_PAGE_WIDTH: width_q = data[WIDTH_W-1:0];
			REG_RECT_COUNT: rcount_q = data[RCOUNT_W-1:0];
			REG_RECT0:      rect_q[0] = data;
			REG_RECT1:      rect_q[1] = data;
			REG_RECT2:      rect_q[2] = data;
			REG_RECT3:      rect_q[3] = data;
			default: ;
		endcase
	endfunction

	function automatic void add_pix(input logic [31:0] tgt, input logic [31:0] src,
			input bit last, input bit typed = 0, input bit val = 0);
		dir_row_t row;
		row.kind = ROW_PIXEL;
		row.idx = '0;
		row.data = '0;
		row.item.pair = {tgt, src};
		row.item.last = last;
		row.typed = typed;
		row.typed_val = val;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		dir_row_t row;
		row.kind = ROW_WRITE;
		row.idx = idx;
		row.data = data;
		row.item = '0;
		row.typed = 0;
		row.typed_val = 0;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	// noisy channels match, differ by exactly the threshold, one above it (at most 255), or anything
	function automatic pixel_item_t random_pixel(input bit noisy, input bit last);
		pixel_item_t       it;
		logic [31:0]       tgt;
		logic [31:0]       src;
		logic [CHAN_W-1:0] t;
		logic [CHAN_W-1:0] s;
		logic [CHAN_W-1:0] swap;
		int                d;
		int                mode;
		tgt = 0;
		src = 0;
		for (int c = 0; c < 4; c++) begin
			t = CHAN_W'($urandom);
			s = t;
			mode = noisy ? $urandom_range(3) : 0;
			if (mode == 3) begin
				s = CHAN_W'($urandom);
			end else if (mode != 0) begin
				d = int'(thr_q) + mode - 1;
				if (d > 255)
					d = 255;
				t = CHAN_W'($urandom_range(255, d));
				s = CHAN_W'(int'(t) - d);
				if ($urandom_range(1)) begin
					swap = t;
					t = s;
					s = swap;
				end
			end
			tgt = (tgt << 8) | 32'(t);
			src = (src << 8) | 32'(s);
		end
		it.pair = {tgt, src};
		it.last = last;
		return it;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		apply_write(idx, data);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_idle(input int tail);
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (differs_due.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic push_pixel(input pixel_item_t it, input bit typed, input bit typed_val);
		bit done;
		bit differs;
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 34) begin
			pix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.tgt_cyan <= it.pair.tgt_cyan;
		pix_ch.tgt_magenta <= it.pair.tgt_magenta;
		pix_ch.tgt_yellow <= it.pair.tgt_yellow;
		pix_ch.tgt_black <= it.pair.tgt_black;
		pix_ch.src_cyan <= it.pair.src_cyan;
		pix_ch.src_magenta <= it.pair.src_magenta;
		pix_ch.src_yellow <= it.pair.src_yellow;
		pix_ch.src_black <= it.pair.src_black;
		pix_ch.last_pixel <= it.last;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		page_diff_step(it, done, differs);
		if (done)
			differs_due.insert(differs_due.size(), typed ? typed_val : differs);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side: random ready, plus one long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end else begin
				res_ch.ready <= !gaps_on || ($urandom_range(99) >= 34);
			end
		end
	end

	always @(posedge clk) begin : res_check
		bit pending;
		bit want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			pending = differs_due.size() != 0;
			want = 0;
			if (pending)
				want = differs_due.pop_front();
			if (!pending || want !== res_ch.page_differs) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					if (!pending)
						$display("%0t: page_differs %b with no page pending", $realtime,
							res_ch.page_differs);
					else
						$display("%0t: page_differs expected %b actual %b", $realtime, want,
							res_ch.page_differs);
				end
			end
		end
	end

	// stall watchdog: any transfer on either channel resets it
	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int                    phase_pixels;
		int                    page_len;
		int                    noise_pct;
		logic [15:0]           l, t, r, b;
		logic [CFG_DATA_W-1:0] junk;
		logic [CFG_DATA_W-1:0] val;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.tgt_cyan = '0;
		pix_ch.tgt_magenta = '0;
		pix_ch.tgt_yellow = '0;
		pix_ch.tgt_black = '0;
		pix_ch.src_cyan = '0;
		pix_ch.src_magenta = '0;
		pix_ch.src_yellow = '0;
		pix_ch.src_black = '0;
		pix_ch.last_pixel = 1'b0;
		thr_q = 0;
		width_q = 1;
		rcount_q = 0;
		foreach (rect_q[i])
			rect_q[i] = '0;
		col_q = 0;
		row_q = 0;
		differs_q = 0;

		// reset settings: threshold 0, one pixel per row, no rectangles
		add_pix(32'h0, 32'h0, 1, 1, 0);
		add_pix(32'h01000000, 32'h0, 1, 1, 1);
		add_pix(32'h0, 32'hFFFFFFFF, 1, 1, 1);
		add_pix(32'h00FF0000, 32'h0, 1, 1, 1);
		add_pix(32'h0, 32'h0000FF00, 1, 1, 1);
		add_pix(32'h000000FF, 32'h0, 1, 1, 1);
		add_pix(32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, 0);
		// flag is sticky within a page and cleared after it
		add_pix(32'hFFFFFFFF, 32'h0, 0);
		add_pix(32'h5A5A5A5A, 32'h5A5A5A5A, 1, 1, 1);
		add_pix(32'h5A5A5A5A, 32'h5A5A5A5A, 1, 1, 0);
		add_write(REG_THRESHOLD, 64'd255);
		add_pix(32'hFFFFFFFF, 32'h0, 1, 1, 0);
		add_write(REG_THRESHOLD, 64'd254);
		add_pix(32'hFFFFFFFF, 32'h0, 1, 1, 1);
		// 3-wide page, one rectangle covering only column 1 of row 1
		add_write(REG_THRESHOLD, 64'd0);
		add_write(REG_PAGE_WIDTH, 64'd3);
		add_write(REG_RECT0, rect_pack(1, 1, 2, 2));
		add_write(REG_RECT_COUNT, 64'd1);
		for (int k = 0; k < 6; k++)
			add_pix((k == 4) ? 32'h80808080 : 32'h0, 32'h0, k == 5);
		for (int k = 0; k < 3; k++)
			add_pix((k == 2) ? 32'h80808080 : 32'h0, 32'h0, k == 2);
		// unmapped index, zero width, saturated count, empty rectangle in slot 0
		add_write(REG_SPARE, '1);
		add_write(REG_PAGE_WIDTH, 64'd0);
		add_write(REG_RECT3, rect_pack(0, 1, 1, 2));
		add_write(REG_RECT0, rect_pack(3, 0, 0, 9));
		add_write(REG_RECT_COUNT, 64'd7);
		add_pix(32'h0, 32'h0, 0);
		add_pix(32'hFFFFFFFF, 32'h0, 0);
		add_pix(32'h0, 32'h0, 1);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[n]) begin
			if (dir_rows[n].kind == ROW_WRITE) begin
				wait_idle(PAGE_TAIL);
				write_reg(dir_rows[n].idx, dir_rows[n].data);
			end else begin
				push_pixel(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].typed_val);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle(PAGE_TAIL);
			gaps_on = !(ph == 5 || ph == 6);

			junk = {$urandom, $urandom};
			case ($urandom_range(4))
				0: val = 0;
				1: val = 255;
				2: val = 64'($urandom_range(255));
				default: val = 64'($urandom_range(20));
			endcase
			write_reg(REG_THRESHOLD, {junk[63:THRESH_W], val[THRESH_W-1:0]});

			junk = {$urandom, $urandom};
			case ($urandom_range(9))
				0: val = 0;
				1: val = 65535;
				2: val = 64'($urandom_range(65535));
				default: val = 64'($urandom_range(8, 1));
			endcase
			write_reg(REG_PAGE_WIDTH, {junk[63:WIDTH_W], val[WIDTH_W-1:0]});

			junk = {$urandom, $urandom};
			write_reg(REG_RECT_COUNT, {junk[63:RCOUNT_W], 3'($urandom_range(7))});

			for (int i = 0; i < MAX_RECTS_DEF; i++) begin
				case ($urandom_range(9))
					0: val = {$urandom, $urandom};
					1: begin
						// left not below right: covers nothing
						l = 16'($urandom_range(12));
						r = 16'($urandom_range(l));
						t = 16'($urandom_range(8));
						b = 16'(t + $urandom_range(6, 1));
						val = rect_pack(l, t, r, b);
					end
					default: begin
						l = 16'($urandom_range(6));
						r = 16'(l + $urandom_range(5));
						t = 16'($urandom_range(8));
						b = 16'(t + $urandom_range(6));
						val = rect_pack(l, t, r, b);
					end
				endcase
				write_reg(CFG_IDX_W'(REG_RECT0 + i), val);
			end
			if ($urandom_range(2) == 0)
				write_reg(REG_SPARE, {$urandom, $urandom});

			// one phase of short pages against a stalled result side
			if (ph == 3)
				hold_req = 1;

			phase_pixels = 0;
			while (phase_pixels < PHASE_PIXELS) begin
				page_len = (ph == 3) ? $urandom_range(3, 1) : $urandom_range(24, 1);
				case ($urandom_range(2))
					0: noise_pct = 0;
					1: noise_pct = 4;
					default: noise_pct = 30;
				endcase
				for (int k = 0; k < page_len; k++)
					push_pixel(random_pixel($urandom_range(99) < noise_pct, k == page_len - 1),
						0, 0);
				phase_pixels += page_len;
			end
		end

		@(negedge clk);
		pix_ch.valid <= 1'b0;
		wait_idle(10);
		if (mismatches == 0 && differs_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
